>>> hdl/crdg_pkg.sv
// shared types and constants of the camera ray direction generator
`timescale 1ns / 1ps

package crdg_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 512;

	typedef enum logic [2:0] {
		CFG_CAMERA_X    = 3'd0,
		CFG_CAMERA_Y    = 3'd1,
		CFG_CAMERA_Z    = 3'd2,
		CFG_LOOK_X      = 3'd3,
		CFG_LOOK_Y      = 3'd4,
		CFG_LOOK_Z      = 3'd5,
		CFG_FOCAL_SCALE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [17:0] pixel_x;
		logic [16:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic               degenerate;
	} result_t;

	typedef struct packed {
		logic basis;
		logic deg;
	} norm_tag_t;

	typedef struct packed {
		logic              valid;
		norm_tag_t         tag;
		logic              nz;
		logic [2:0][31:0]  d;
	} norm_out_t;

endpackage

>>> hdl/camera_ray_direction_generator_core.sv
// top level: camera basis sequencer, ray sum pipeline and shared normalizer
`timescale 1ns / 1ps

// channel   | signals                        | handshake
// ----------+--------------------------------+------------------------------
// pixel in  | pixel                          | start high, busy low
// ray out   | result                         | done high for one cycle
// config    | cfg_we, cfg_idx, cfg_wdata     | cfg_we high, no wait
//
// one pixel per cycle while busy is low; each ray goes through the
// 70-stage normalizer (32-step square root, 31-step divide).
// after reset and after every config write the camera axes are rebuilt,
// forward and right through the same normalizer; busy stays high meanwhile.
// results cannot be held off, so nothing in the pipeline ever stalls.

module camera_ray_direction_generator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  crdg_pkg::pixel_t     pixel,
	output logic                 done,
	output crdg_pkg::result_t    result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [31:0]          cfg_wdata
);
	localparam int U_BASE = crdg_pkg::IMAGE_WIDTH * 65536;
	localparam int V_BASE = crdg_pkg::IMAGE_HEIGHT * 65536;

	typedef enum logic [2:0] {
		ST_DRAIN,
		ST_FWD,
		ST_FWD_WAIT,
		ST_RGT,
		ST_RGT_WAIT,
		ST_UP_MUL,
		ST_UP_SUM,
		ST_READY
	} seq_state_t;

	function automatic logic signed [32:0] mul30(input logic signed [63:0] p);
		logic [63:0] m;
		logic [32:0] r;
		m = p[63] ? (~p + 64'd1) : p;
		r = m[62:30];
		return p[63] ? $signed(~r + 33'd1) : $signed(r);
	endfunction

	// configuration
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [31:0] look_x_q, look_y_q, look_z_q;
	logic [30:0]        focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
			look_x_q <= '0;
			look_y_q <= '0;
			look_z_q <= 32'sd65536;
			focal_q  <= 31'd65536;
		end else if (cfg_we) begin
			unique case (crdg_pkg::cfg_idx_t'(cfg_idx))
				crdg_pkg::CFG_CAMERA_X:    cam_x_q  <= cfg_wdata;
				crdg_pkg::CFG_CAMERA_Y:    cam_y_q  <= cfg_wdata;
				crdg_pkg::CFG_CAMERA_Z:    cam_z_q  <= cfg_wdata;
				crdg_pkg::CFG_LOOK_X:      look_x_q <= cfg_wdata;
				crdg_pkg::CFG_LOOK_Y:      look_y_q <= cfg_wdata;
				crdg_pkg::CFG_LOOK_Z:      look_z_q <= cfg_wdata;
				crdg_pkg::CFG_FOCAL_SCALE: focal_q  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// camera basis
	seq_state_t                state_q;
	logic signed [31:0]        k_q [3];
	logic signed [31:0]        ri_q [3];
	logic signed [32:0]        j_q [3];
	logic signed [63:0]        jp_q [4];
	logic                      deg_q;

	crdg_pkg::norm_out_t       nout;
	logic                      n_active;
	logic                      front_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DRAIN;
			deg_q   <= 1'b0;
		end else if (cfg_we) begin
			state_q <= ST_DRAIN;
		end else begin
			unique case (state_q)
				ST_DRAIN: begin
					if (!front_busy && !n_active) begin
						state_q <= ST_FWD;
					end
				end
				ST_FWD: state_q <= ST_FWD_WAIT;
				ST_FWD_WAIT: begin
					if (nout.valid && nout.tag.basis) begin
						for (int i = 0; i < 3; i++) begin
							k_q[i] <= $signed(nout.d[i]);
						end
						if (nout.nz) begin
							state_q <= ST_RGT;
						end else begin
							deg_q   <= 1'b1;
							state_q <= ST_READY;
						end
					end
				end
				ST_RGT: state_q <= ST_RGT_WAIT;
				ST_RGT_WAIT: begin
					if (nout.valid && nout.tag.basis) begin
						for (int i = 0; i < 3; i++) begin
							ri_q[i] <= $signed(nout.d[i]);
						end
						if (nout.nz) begin
							state_q <= ST_UP_MUL;
						end else begin
							deg_q   <= 1'b1;
							state_q <= ST_READY;
						end
					end
				end
				ST_UP_MUL: begin
					jp_q[0] <= ri_q[2] * k_q[1];
					jp_q[1] <= ri_q[2] * k_q[0];
					jp_q[2] <= ri_q[0] * k_q[2];
					jp_q[3] <= ri_q[0] * k_q[1];
					state_q <= ST_UP_SUM;
				end
				ST_UP_SUM: begin
					j_q[0]  <= -mul30(jp_q[0]);
					j_q[1]  <= mul30(jp_q[1]) - mul30(jp_q[2]);
					j_q[2]  <= mul30(jp_q[3]);
					deg_q   <= 1'b0;
					state_q <= ST_READY;
				end
				ST_READY: ;
				default: state_q <= ST_DRAIN;
			endcase
		end
	end

	assign busy = (state_q != ST_READY);

	// ray sum pipeline
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	crdg_pkg::pixel_t    pix_s1;
	logic signed [31:0]  num_u, num_v;
	logic signed [31:0]  u_s2, v_s2;
	logic signed [63:0]  pu_s3 [3];
	logic signed [63:0]  pv_s3 [3];
	logic signed [63:0]  pf_s3 [3];
	logic [2:0][63:0]    s_s4;
	logic                deg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign front_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4;

	assign num_u = 32'(U_BASE) - $signed({5'b0, pix_s1.pixel_x, 9'b0});
	assign num_v = 32'(V_BASE) - $signed({6'b0, pix_s1.pixel_y, 9'b0});

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
		u_s2   <= 32'(num_u / crdg_pkg::IMAGE_HEIGHT);
		v_s2   <= 32'(num_v / crdg_pkg::IMAGE_WIDTH);
		for (int i = 0; i < 3; i++) begin
			pu_s3[i] <= u_s2 * ri_q[i];
			pv_s3[i] <= v_s2 * j_q[i];
			pf_s3[i] <= $signed({1'b0, focal_q}) * k_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			s_s4[i] <= deg_q ? 64'd0 : 64'(pu_s3[i] + pv_s3[i] + pf_s3[i]);
		end
		deg_s4 <= deg_q;
	end

	// normalizer input select
	logic                inj;
	logic [2:0][63:0]    n_vec;
	crdg_pkg::norm_tag_t n_tag;
	logic signed [63:0]  fx, fy, fz;

	assign fx = look_x_q - cam_x_q;
	assign fy = look_y_q - cam_y_q;
	assign fz = look_z_q - cam_z_q;

	always_comb begin
		inj = (state_q == ST_FWD) || (state_q == ST_RGT);
		n_tag.basis = inj;
		n_tag.deg   = inj ? 1'b0 : deg_s4;
		if (state_q == ST_FWD) begin
			n_vec[0] = fx;
			n_vec[1] = fy;
			n_vec[2] = fz;
		end else if (state_q == ST_RGT) begin
			n_vec[0] = -64'(k_q[2]);
			n_vec[1] = 64'd0;
			n_vec[2] = 64'(k_q[0]);
		end else begin
			n_vec = s_s4;
		end
	end

	crdg_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s4 | inj),
		.in_tag   (n_tag),
		.in_vec   (n_vec),
		.out      (nout),
		.active   (n_active)
	);

	assign done              = nout.valid && !nout.tag.basis;
	assign result.dir_x      = $signed(nout.d[0]);
	assign result.dir_y      = $signed(nout.d[1]);
	assign result.dir_z      = $signed(nout.d[2]);
	assign result.degenerate = nout.tag.deg;

endmodule

>>> hdl/crdg_norm.sv
// pipelined 3-vector normalizer: scale, square sum, square root, divide
`timescale 1ns / 1ps

module crdg_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  crdg_pkg::norm_tag_t   in_tag,
	input  logic [2:0][63:0]      in_vec,
	output crdg_pkg::norm_out_t   out,
	output logic                  active
);
	localparam int RT_STAGES = 32;
	localparam int DV_STAGES = 31;
	localparam int ALL_STAGES = 6 + RT_STAGES + DV_STAGES + 1;

	logic [ALL_STAGES-1:0] vld_sn;
	crdg_pkg::norm_tag_t   tag_sn [ALL_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			vld_sn <= {vld_sn[ALL_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		tag_sn[0] <= in_tag;
		for (int k = 1; k < ALL_STAGES; k++) begin
			tag_sn[k] <= tag_sn[k-1];
		end
	end

	assign active = |vld_sn;

	// magnitudes
	logic [2:0][63:0] mag_s1;
	logic [2:0]       neg_s1;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= in_vec[i][63];
			mag_s1[i] <= in_vec[i][63] ? (~in_vec[i] + 64'd1) : in_vec[i];
		end
	end

	// leading one per byte
	logic [63:0]      orw;
	logic [7:0]       gnz_c;
	logic [7:0][2:0]  gpos_c;
	logic [2:0][63:0] mag_s2;
	logic [2:0]       neg_s2;
	logic [7:0]       gnz_s2;
	logic [7:0][2:0]  gpos_s2;

	always_comb begin
		orw = mag_s1[0] | mag_s1[1] | mag_s1[2];
		for (int g = 0; g < 8; g++) begin
			gnz_c[g] = |orw[8*g +: 8];
			gpos_c[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (orw[8*g + b]) begin
					gpos_c[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		gnz_s2  <= gnz_c;
		gpos_s2 <= gpos_c;
	end

	// leading one of the word
	logic [5:0]       pos_c;
	logic [5:0]       pos_s3;
	logic             zero_s3;
	logic [2:0][63:0] mag_s3;
	logic [2:0]       neg_s3;

	always_comb begin
		pos_c = 6'd0;
		for (int g = 0; g < 8; g++) begin
			if (gnz_s2[g]) begin
				pos_c = {3'(g), gpos_s2[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s3  <= pos_c;
		zero_s3 <= ~|gnz_s2;
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
	end

	// scale so the largest lies in [2^29, 2^30)
	logic [2:0][63:0] sh_c;
	logic [2:0][29:0] m30_s4;
	logic             zero_s4;
	logic [2:0]       neg_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= 6'd29) begin
				sh_c[i] = mag_s3[i] >> (pos_s3 - 6'd29);
			end else begin
				sh_c[i] = mag_s3[i] << (6'd29 - pos_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m30_s4[i] <= sh_c[i][29:0];
		end
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
	end

	// squares
	logic [2:0][59:0] sq_s5;
	logic [2:0][29:0] m30_s5;
	logic             zero_s5;
	logic [2:0]       neg_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= m30_s4[i] * m30_s4[i];
		end
		m30_s5  <= m30_s4;
		zero_s5 <= zero_s4;
		neg_s5  <= neg_s4;
	end

	// sum of squares
	logic [61:0]      sum_s6;
	logic [2:0][29:0] m30_s6;
	logic             zero_s6;
	logic [2:0]       neg_s6;

	always_ff @(posedge clk) begin
		sum_s6  <= {2'b0, sq_s5[0]} + {2'b0, sq_s5[1]} + {2'b0, sq_s5[2]};
		m30_s6  <= m30_s5;
		zero_s6 <= zero_s5;
		neg_s6  <= neg_s5;
	end

	// square root, one result bit per stage
	logic [63:0]      rt_rem_s7 [RT_STAGES+1];
	logic [63:0]      rt_res_s7 [RT_STAGES+1];
	logic [2:0][29:0] rt_m30_s7 [RT_STAGES+1];
	logic             rt_zero_s7 [RT_STAGES+1];
	logic [2:0]       rt_neg_s7 [RT_STAGES+1];

	assign rt_rem_s7[0]  = {2'b0, sum_s6};
	assign rt_res_s7[0]  = 64'd0;
	assign rt_m30_s7[0]  = m30_s6;
	assign rt_zero_s7[0] = zero_s6;
	assign rt_neg_s7[0]  = neg_s6;

	for (genvar k = 0; k < RT_STAGES; k++) begin : g_rt
		localparam logic [63:0] RT_BIT = 64'd1 << (62 - 2*k);
		logic [63:0] trial;
		assign trial = rt_res_s7[k] + RT_BIT;
		always_ff @(posedge clk) begin
			if (rt_rem_s7[k] >= trial) begin
				rt_rem_s7[k+1] <= rt_rem_s7[k] - trial;
				rt_res_s7[k+1] <= (rt_res_s7[k] >> 1) + RT_BIT;
			end else begin
				rt_rem_s7[k+1] <= rt_rem_s7[k];
				rt_res_s7[k+1] <= rt_res_s7[k] >> 1;
			end
			rt_m30_s7[k+1]  <= rt_m30_s7[k];
			rt_zero_s7[k+1] <= rt_zero_s7[k];
			rt_neg_s7[k+1]  <= rt_neg_s7[k];
		end
	end

	// divide each magnitude by the length, one quotient bit per stage
	logic [2:0][31:0] dv_rem_s8 [DV_STAGES+1];
	logic [2:0][30:0] dv_quo_s8 [DV_STAGES+1];
	logic [2:0][29:0] dv_m30_s8 [DV_STAGES+1];
	logic [30:0]      dv_len_s8 [DV_STAGES+1];
	logic             dv_zero_s8 [DV_STAGES+1];
	logic [2:0]       dv_neg_s8 [DV_STAGES+1];

	for (genvar i = 0; i < 3; i++) begin : g_dv_init
		assign dv_rem_s8[0][i] = {3'b0, rt_m30_s7[RT_STAGES][i][29:1]};
		assign dv_quo_s8[0][i] = 31'd0;
	end
	assign dv_m30_s8[0]  = rt_m30_s7[RT_STAGES];
	assign dv_len_s8[0]  = rt_res_s7[RT_STAGES][30:0];
	assign dv_zero_s8[0] = rt_zero_s7[RT_STAGES];
	assign dv_neg_s8[0]  = rt_neg_s7[RT_STAGES];

	for (genvar j = 0; j < DV_STAGES; j++) begin : g_dv
		localparam int QB = DV_STAGES - 1 - j;
		logic [2:0][31:0] rr;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rr[i] = {dv_rem_s8[j][i][30:0], (QB == DV_STAGES - 1) ? dv_m30_s8[j][i][0] : 1'b0};
				ge[i] = rr[i] >= {1'b0, dv_len_s8[j]};
			end
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s8[j+1][i] <= ge[i] ? (rr[i] - {1'b0, dv_len_s8[j]}) : rr[i];
				dv_quo_s8[j+1][i] <= dv_quo_s8[j][i] | (31'(ge[i]) << QB);
			end
			dv_m30_s8[j+1]  <= dv_m30_s8[j];
			dv_len_s8[j+1]  <= dv_len_s8[j];
			dv_zero_s8[j+1] <= dv_zero_s8[j];
			dv_neg_s8[j+1]  <= dv_neg_s8[j];
		end
	end

	// sign and zero handling
	logic [2:0][31:0] d_s9;
	logic             nz_s9;
	logic [2:0][31:0] qx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qx[i] = {1'b0, dv_quo_s8[DV_STAGES][i]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s8[DV_STAGES]) begin
				d_s9[i] <= 32'd0;
			end else if (dv_neg_s8[DV_STAGES][i]) begin
				d_s9[i] <= ~qx[i] + 32'd1;
			end else begin
				d_s9[i] <= qx[i];
			end
		end
		nz_s9 <= ~dv_zero_s8[DV_STAGES];
	end

	assign out.valid = vld_sn[ALL_STAGES-1];
	assign out.tag   = tag_sn[ALL_STAGES-1];
	assign out.nz    = nz_s9;
	assign out.d     = d_s9;

endmodule

>>> tb/camera_ray_direction_generator_core_test.sv
// self-checking testbench of the camera ray direction generator core
`timescale 1ns / 1ps

module camera_ray_direction_generator_core_test;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;

	typedef longint vec3_t [3];
	typedef struct {
		crdg_pkg::pixel_t px;
		bit               drain;
	} pixel_item_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	crdg_pkg::pixel_t  pixel = '0;
	logic              done;
	crdg_pkg::result_t result;
	logic              cfg_we = 0;
	logic [2:0]        cfg_idx = '0;
	logic [31:0]       cfg_wdata = '0;

	camera_ray_direction_generator_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	logic signed [31:0] cam_pos [3];
	logic signed [31:0] look_at [3];
	logic [30:0]        focal;

	pixel_item_t       pixel_queue [$];
	crdg_pkg::result_t pending_rays [$];
	int          errors = 0;
	int          rays_checked = 0;
	int          degenerate_seen = 0;
	int          gap_left = 0;
	bit          quiet = 0;
	longint      cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic bit unit_vec(input vec3_t v, output vec3_t o);
		longint unsigned m [3];
		longint unsigned mx, len;
		longint q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		o = '{0, 0, 0};
		if (mx == 0)
			return 0;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = longint'((m[i] << 30) / len);
			o[i] = (v[i] < 0) ? -q : q;
		end
		return 1;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		longint p, r;
		p = a * b;
		r = ((p < 0) ? -p : p) >>> 30;
		return (p < 0) ? -r : r;
	endfunction

	function automatic crdg_pkg::result_t predict_ray(input crdg_pkg::pixel_t p);
		longint px, py, u, v;
		vec3_t fwd, fwd_n, right, right_n, upv, ray, dir;
		crdg_pkg::result_t r;
		px = longint'(p.pixel_x);
		py = longint'(p.pixel_y);
		u = ((longint'(crdg_pkg::IMAGE_WIDTH) * 256 - 2 * px) * 256) /
			longint'(crdg_pkg::IMAGE_HEIGHT);
		v = ((longint'(crdg_pkg::IMAGE_HEIGHT) * 256 - 2 * py) * 256) /
			longint'(crdg_pkg::IMAGE_WIDTH);
		dir = '{0, 0, 0};
		r.degenerate = 0;
		for (int i = 0; i < 3; i++)
			fwd[i] = longint'(look_at[i]) - longint'(cam_pos[i]);
		if (!unit_vec(fwd, fwd_n)) begin
			r.degenerate = 1;
		end else begin
			right = '{-fwd_n[2], 0, fwd_n[0]};
			if (!unit_vec(right, right_n)) begin
				r.degenerate = 1;
			end else begin
				upv[0] = -mul_q30(right_n[2], fwd_n[1]);
				upv[1] = mul_q30(right_n[2], fwd_n[0]) - mul_q30(right_n[0], fwd_n[2]);
				upv[2] = mul_q30(right_n[0], fwd_n[1]);
				for (int i = 0; i < 3; i++)
					ray[i] = u * right_n[i] + v * upv[i] + longint'(focal) * fwd_n[i];
				void'(unit_vec(ray, dir));
			end
		end
		r.dir_x = dir[0][31:0];
		r.dir_y = dir[1][31:0];
		r.dir_z = dir[2][31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65)
			return 0;
		if (roll < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	task automatic report(input string field, input longint got, input longint want);
		errors++;
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit nstart;
		crdg_pkg::pixel_t npix;
		if (!arst_n) begin
			start <= 0;
			gap_left = 0;
		end else begin
			nstart = start;
			npix = pixel;
			if (start && !busy) begin
				pending_rays.push_back(predict_ray(pixel));
				nstart = 0;
				gap_left = quiet ? 0 : pick_gap();
			end
			if (!nstart) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pixel_queue.size() != 0 &&
						(!pixel_queue[0].drain || pending_rays.size() == 0)) begin
					npix = pixel_queue[0].px;
					void'(pixel_queue.pop_front());
					nstart = 1;
				end
			end
			start <= nstart;
			pixel <= npix;
		end
	end

	// monitor
	always @(posedge clk) begin
		crdg_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_rays.size() == 0) begin
				errors++;
				$display("unexpected result at %0t", $time);
			end else begin
				want = pending_rays.pop_front();
				rays_checked++;
				if (want.degenerate)
					degenerate_seen++;
				if (result.dir_x !== want.dir_x)
					report("dir_x", result.dir_x, want.dir_x);
				if (result.dir_y !== want.dir_y)
					report("dir_y", result.dir_y, want.dir_y);
				if (result.dir_z !== want.dir_z)
					report("dir_z", result.dir_z, want.dir_z);
				if (result.degenerate !== want.degenerate)
					report("degenerate", result.degenerate, want.degenerate);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		case (idx)
			crdg_pkg::CFG_CAMERA_X:    cam_pos[0] = data;
			crdg_pkg::CFG_CAMERA_Y:    cam_pos[1] = data;
			crdg_pkg::CFG_CAMERA_Z:    cam_pos[2] = data;
			crdg_pkg::CFG_LOOK_X:      look_at[0] = data;
			crdg_pkg::CFG_LOOK_Y:      look_at[1] = data;
			crdg_pkg::CFG_LOOK_Z:      look_at[2] = data;
			crdg_pkg::CFG_FOCAL_SCALE: focal = data[30:0];
			default: ;
		endcase
	endtask

	task automatic set_camera(input logic [31:0] c [3], input logic [31:0] l [3],
			input logic [31:0] fs);
		write_reg(crdg_pkg::CFG_CAMERA_X, c[0]);
		write_reg(crdg_pkg::CFG_CAMERA_Y, c[1]);
		write_reg(crdg_pkg::CFG_CAMERA_Z, c[2]);
		write_reg(crdg_pkg::CFG_LOOK_X, l[0]);
		write_reg(crdg_pkg::CFG_LOOK_Y, l[1]);
		write_reg(crdg_pkg::CFG_LOOK_Z, l[2]);
		write_reg(crdg_pkg::CFG_FOCAL_SCALE, fs);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic add_pixel(input int x, input int y, input bit drain);
		pixel_item_t it;
		it.px.pixel_x = x[17:0];
		it.px.pixel_y = y[16:0];
		it.drain = drain;
		pixel_queue.push_back(it);
	endtask

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0)
				add_pixel($urandom_range(262143), $urandom_range(131071),
					$urandom_range(40) == 0);
			else
				add_pixel($urandom_range(262143, 0) & 32'h3ffff,
					$urandom_range(512 * 256 - 1), 0);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_queue.size() != 0 || start || pending_rays.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] c [3];
		logic [31:0] l [3];
		cam_pos = '{32'sd0, 32'sd0, 32'sd0};
		look_at = '{32'sd0, 32'sd0, 32'sd65536};
		focal = 31'd65536;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// reset camera: pixel extremes, image center, single-bit coordinates, random pixels
		add_pixel(0, 0, 0);
		add_pixel(262143, 131071, 0);
		add_pixel(131072, 65536, 0);
		add_pixel(0, 131071, 0);
		add_pixel(262143, 0, 0);
		add_pixel(1024 * 256 - 1, 512 * 256 - 1, 0);
		for (int b = 0; b < 18; b += 3)
			add_pixel(1 << b, 1 << (b % 17), 0);
		add_pixel(12345, 6789, 1);
		add_random(150);
		wait_idle();

		// zero focal scale with the center pixel: ray sum vanishes
		c = '{0, 0, 0};
		l = '{0, 0, 32'h0001_0000};
		set_camera(c, l, 0);
		write_reg(CFG_UNUSED, 32'hdead_beef);
		@(posedge clk);
		cfg_we <= 0;
		add_pixel(131072, 65536, 0);
		add_pixel(131073, 65536, 0);
		add_random(60);
		wait_idle();

		// camera on the look-at point
		c = '{32'h0003_0000, 32'hfffe_0000, 32'h1234_5678};
		set_camera(c, c, 32'h0002_0000);
		add_random(30);
		wait_idle();

		// looking straight up, then straight down
		c = '{32'h0001_0000, 0, 32'hffff_0000};
		l = '{32'h0001_0000, 32'h0100_0000, 32'hffff_0000};
		set_camera(c, l, 32'h0001_0000);
		add_random(30);
		wait_idle();
		l = '{32'h0001_0000, 32'h8000_0000, 32'hffff_0000};
		set_camera(c, l, 32'h7fff_ffff);
		add_random(30);
		wait_idle();

		// register extremes
		c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		l = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		set_camera(c, l, 32'h7fff_ffff);
		add_random(100);
		wait_idle();
		set_camera(l, c, 32'hffff_ffff);
		quiet = 1;
		add_random(100);
		wait_idle();
		quiet = 0;

		// random cameras, one nearly parallel to up
		for (int ph = 0; ph < 12; ph++) begin
			for (int i = 0; i < 3; i++) begin
				c[i] = $urandom;
				l[i] = (ph % 3 == 0) ? $urandom_range(65535) - 32768 : $urandom;
			end
			if (ph == 4) begin
				l[0] = c[0] + 1;
				l[1] = c[1] + 32'h0100_0000;
				l[2] = c[2];
			end
			set_camera(c, l, (ph % 4 == 0) ? $urandom : $urandom_range(32'h0004_0000));
			quiet = (ph == 7);
			add_random(100);
			wait_idle();
		end

		$display("checked %0d rays over 19 camera settings, %0d of them degenerate",
			rays_checked, degenerate_seen);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> camera_ray_direction_generator_core.f
hdl/crdg_pkg.sv
hdl/crdg_norm.sv
hdl/camera_ray_direction_generator_core.sv
tb/camera_ray_direction_generator_core_test.sv
